@@ rtl/core/fdxb_pkg.sv @@
// Package for the FDX-B tag line parser: beat structs, codes, header tables.
// Used by fdxb_b2d and fdxb_tag_line_parser_fifo_core. No dependencies.
`default_nettype none
package fdxb_pkg;

   localparam int LineMax    = 32;
   localparam int LineAw     = 5;
   localparam int QueueDepth = 16;
   localparam int QueueAw    = 4;
   localparam int BinWidth   = 32;
   localparam int BcdDigits  = 10;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] verdict;
      logic [7:0] id_char;
      logic       id_empty;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [BinWidth-1:0]   value;
   } b2d_req_type;

   typedef struct packed {
      logic                  done;
      logic [4*BcdDigits-1:0] bcd;
   } b2d_rsp_type;

   localparam logic       OP_BYTE      = 1'b0;
   localparam logic       OP_TAKE      = 1'b1;
   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_CHAR    = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] VERD_STORED  = 2'd0;
   localparam logic [1:0] VERD_DROPPED = 2'd1;
   localparam logic [1:0] VERD_DUP     = 2'd2;
   localparam logic [1:0] VERD_REJECT  = 2'd3;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [BinWidth-1:0] VAL_SAT = 32'h7FFF_FFFF;

   // ":FDXB(S)="
   function automatic logic [7:0] head_s_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0: c = 8'h3A;
         4'd1: c = 8'h46;
         4'd2: c = 8'h44;
         4'd3: c = 8'h58;
         4'd4: c = 8'h42;
         4'd5: c = 8'h28;
         4'd6: c = 8'h53;
         4'd7: c = 8'h29;
         4'd8: c = 8'h3D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // ":FDXB="
   function automatic logic [7:0] head_n_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h3A;
         3'd1: c = 8'h46;
         3'd2: c = 8'h44;
         3'd3: c = 8'h58;
         3'd4: c = 8'h42;
         3'd5: c = 8'h3D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "999000"
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      return (idx < 3'd3) ? 8'h39 : 8'h30;
   endfunction

   // Byte pairs taken in the order 3,2,1,0.
   function automatic logic [2:0] order_pos(input logic [2:0] i);
      return {~i[2:1], i[0]};
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else                               r = 5'd0;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/fdxb_b2d.sv @@
// Serial binary to BCD converter, one bit per cycle (shift and add 3).
// Depends on fdxb_pkg.
`default_nettype none
module fdxb_b2d (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fdxb_pkg::b2d_req_type ctl,
   output fdxb_pkg::b2d_rsp_type      stat
);
   import fdxb_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [BinWidth-1:0]    bin_ff, bin_in;
   logic [4*BcdDigits-1:0] bcd_ff, bcd_in;
   logic [4*BcdDigits-1:0] adj;

   always_comb begin
      for (int d = 0; d < BcdDigits; d++) begin
         adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                     : bcd_ff[4*d +: 4];
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = ctl.value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[4*BcdDigits-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(BinWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.done = done_ff;
   assign stat.bcd  = bcd_ff;

endmodule
`default_nettype wire

@@ rtl/core/fdxb_tag_line_parser_fifo_core.sv @@
// FDX-B tag line parser with a bounded tag ID queue (top level).
// Depends on fdxb_pkg and fdxb_b2d.
//
//   channel | ports                          | moves
//   req     | req_valid/req_stall/req_data   | received byte or take request
//   rsp     | rsp_valid/rsp_stall/rsp_data   | verdict, ID character or empty
//   csr     | csr_valid/csr_ready/csr_wdata  | max_entries
//
// An ordinary byte is accepted while idle. A carriage return on a rejected line
// goes straight to the verdict; else the ID is compared per character with the
// newest ID if that has the same length and, unless a duplicate, is written per
// character after dropping the oldest as needed; ":FDXB=" first converts to BCD.
// A take emits a beat per ID character, or one when the queue or ID is empty.
// Reset is synchronous and clears control state; memories are not cleared.
// A stalled rsp holds the engine; req_stall is high while busy.
`default_nettype none
module fdxb_tag_line_parser_fifo_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire fdxb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output fdxb_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [4:0]       csr_wdata
);
   import fdxb_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CONV    = 4'd1;
   localparam logic [3:0] S_DECIDE  = 4'd2;
   localparam logic [3:0] S_CMP_RD  = 4'd3;
   localparam logic [3:0] S_CMP_USE = 4'd4;
   localparam logic [3:0] S_DROP    = 4'd5;
   localparam logic [3:0] S_WR_RD   = 4'd6;
   localparam logic [3:0] S_WR_USE  = 4'd7;
   localparam logic [3:0] S_FIN     = 4'd8;
   localparam logic [3:0] S_EMIT    = 4'd9;
   localparam logic [3:0] S_TK_RD   = 4'd10;
   localparam logic [3:0] S_TK_OUT  = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [5:0]          line_len_ff, line_len_in;
   logic                overflow_ff, overflow_in;
   logic                match_s_ff, match_s_in;
   logic                match_n_ff, match_n_in;
   logic [3:0]          hex_dig_ff [8];
   logic [3:0]          hex_dig_in [8];
   logic [7:0]          hex_ok_ff, hex_ok_in;
   logic [4:0]          max_ff, max_in;
   logic [QueueAw-1:0]  head_ff, head_in;
   logic [4:0]          count_ff, count_in;
   logic [5:0]          id_len_ff [QueueDepth];
   logic                is_s_ff, is_s_in;
   logic [5:0]          len_ff, len_in;
   logic [5:0]          k_ff, k_in;
   logic                mism_ff, mism_in;
   logic                dropped_ff, dropped_in;
   logic [QueueAw-1:0]  slot_ff, slot_in;
   rsp_type             pend_ff, pend_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [7:0]          line_mem [LineMax];
   logic [7:0]          line_rd_ff;
   logic [7:0]          id_mem [QueueDepth*LineMax];
   logic [7:0]          id_rd_ff;

   logic                accept, out_free, load;
   logic                line_we, id_we, len_we;
   logic [LineAw-1:0]   line_rd_addr;
   logic [QueueAw+LineAw-1:0] id_addr;
   logic [7:0]          cand_char;
   logic [3:0]          nib_idx;
   logic [4*BcdDigits-1:0] bcd_sh;
   logic [4:0]          hexv;
   logic [BinWidth-1:0] val;
   logic                go;
   logic [2:0]          pos;
   logic                is_s, is_n;
   logic [QueueAw-1:0]  newest;
   logic [4:0]          lim;
   logic [4:0]          over;
   b2d_req_type         b2d_ctl;
   b2d_rsp_type         b2d_stat;

   fdxb_b2d u_b2d (
      .clock (clock),
      .reset (reset),
      .ctl   (b2d_ctl),
      .stat  (b2d_stat)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign line_rd_addr = 5'd9 + k_ff[LineAw-1:0];
   assign id_addr      = {slot_ff, k_ff[LineAw-1:0]};
   assign nib_idx      = len_ff[3:0] - 4'd1 - k_ff[3:0];
   assign bcd_sh       = b2d_stat.bcd >> {nib_idx, 2'b00};

   always_comb begin
      if (is_s_ff)            cand_char = line_rd_ff;
      else if (k_ff < 6'd6)   cand_char = prefix_char(k_ff[2:0]);
      else                    cand_char = CHAR_ZERO + {4'd0, bcd_sh[3:0]};
   end

   always_comb begin
      hexv = hex_value(req_data.rx_byte);
      // Leading hex digits in byte-pair order.
      val = '0;
      go  = 1'b1;
      for (int i = 0; i < 8; i++) begin
         pos = order_pos(3'(i));
         if (go && hex_ok_ff[pos]) val = {val[BinWidth-5:0], hex_dig_ff[pos]};
         else                      go = 1'b0;
      end
      if (val[BinWidth-1]) val = VAL_SAT;
      is_s   = match_s_ff && (line_len_ff >= 6'd9);
      is_n   = match_n_ff && (line_len_ff >= 6'd6);
      newest = head_ff + count_ff[QueueAw-1:0] - 4'd1;
      lim    = (max_ff > 5'(QueueDepth)) ? 5'(QueueDepth) : max_ff;
      over   = count_ff - lim + 5'd1;
   end

   always_comb begin
      state_in     = state_ff;
      line_len_in  = line_len_ff;
      overflow_in  = overflow_ff;
      match_s_in   = match_s_ff;
      match_n_in   = match_n_ff;
      hex_dig_in   = hex_dig_ff;
      hex_ok_in    = hex_ok_ff;
      max_in       = max_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      is_s_in      = is_s_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      mism_in      = mism_ff;
      dropped_in   = dropped_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      load         = 1'b0;
      line_we      = 1'b0;
      id_we        = 1'b0;
      len_we       = 1'b0;
      b2d_ctl.start = 1'b0;
      b2d_ctl.value = val;

      if (csr_valid && csr_ready && csr_wdata != 5'd0) max_in = csr_wdata;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.operation == OP_BYTE) begin
               if (req_data.rx_byte == CHAR_CR) begin
                  line_len_in = '0;
                  overflow_in = 1'b0;
                  pend_in     = '{KIND_VERDICT, VERD_REJECT, 8'd0, 1'b0, 1'b1};
                  k_in        = '0;
                  mism_in     = 1'b0;
                  if (overflow_ff) begin
                     state_in = S_EMIT;
                  end else if (is_s) begin
                     is_s_in  = 1'b1;
                     len_in   = line_len_ff - 6'd9;
                     state_in = S_DECIDE;
                  end else if (is_n && line_len_ff >= 6'd14
                               && hex_ok_ff[order_pos(3'd0)]) begin
                     is_s_in       = 1'b0;
                     b2d_ctl.start = 1'b1;
                     state_in      = S_CONV;
                  end else begin
                     state_in = S_EMIT;
                  end
               end else if (line_len_ff < 6'(LineMax)) begin
                  line_we     = 1'b1;
                  line_len_in = line_len_ff + 6'd1;
                  match_s_in  = ((line_len_ff == 6'd0) || match_s_ff) &&
                                ((line_len_ff >= 6'd9) ||
                                 req_data.rx_byte == head_s_char(line_len_ff[3:0]));
                  match_n_in  = ((line_len_ff == 6'd0) || match_n_ff) &&
                                ((line_len_ff >= 6'd6) ||
                                 req_data.rx_byte == head_n_char(line_len_ff[2:0]));
                  if (line_len_ff >= 6'd6 && line_len_ff < 6'd14) begin
                     hex_dig_in[3'(line_len_ff - 6'd6)] = hexv[3:0];
                     hex_ok_in[3'(line_len_ff - 6'd6)]  = hexv[4];
                  end
               end else begin
                  overflow_in = 1'b1;
               end
            end else if (accept) begin
               k_in = '0;
               if (count_ff == 5'd0) begin
                  pend_in  = '{KIND_EMPTY, VERD_STORED, 8'd0, 1'b0, 1'b1};
                  state_in = S_EMIT;
               end else begin
                  slot_in  = head_ff;
                  len_in   = id_len_ff[head_ff];
                  head_in  = head_ff + 4'd1;
                  count_in = count_ff - 5'd1;
                  if (id_len_ff[head_ff] == 6'd0) begin
                     pend_in  = '{KIND_CHAR, VERD_STORED, 8'd0, 1'b1, 1'b1};
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_TK_RD;
                  end
               end
            end
         end
         S_CONV: begin
            if (b2d_stat.done) begin
               len_in   = (b2d_stat.bcd[4*BcdDigits-1 -: 4] != 4'd0) ? 6'd16 : 6'd15;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (count_ff != 5'd0 && id_len_ff[newest] == len_ff) begin
               slot_in = newest;
               if (len_ff == 6'd0) begin
                  pend_in  = '{KIND_VERDICT, VERD_DUP, 8'd0, 1'b0, 1'b1};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_CMP_RD;
               end
            end else begin
               state_in = S_DROP;
            end
         end
         S_CMP_RD: state_in = S_CMP_USE;
         S_CMP_USE: begin
            mism_in = mism_ff || (cand_char != id_rd_ff);
            if (k_ff + 6'd1 == len_ff) begin
               k_in = '0;
               if (!mism_in) begin
                  pend_in  = '{KIND_VERDICT, VERD_DUP, 8'd0, 1'b0, 1'b1};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_DROP;
               end
            end else begin
               k_in     = k_ff + 6'd1;
               state_in = S_CMP_RD;
            end
         end
         S_DROP: begin
            // Drop the oldest until below the limit.
            k_in = '0;
            if (count_ff >= lim) begin
               head_in    = head_ff + over[QueueAw-1:0];
               count_in   = lim - 5'd1;
               dropped_in = 1'b1;
            end else begin
               dropped_in = 1'b0;
            end
            slot_in  = head_in + count_in[QueueAw-1:0];
            state_in = (len_ff == 6'd0) ? S_FIN : S_WR_RD;
         end
         S_WR_RD: state_in = S_WR_USE;
         S_WR_USE: begin
            id_we = 1'b1;
            if (k_ff + 6'd1 == len_ff) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff + 6'd1;
               state_in = S_WR_RD;
            end
         end
         S_FIN: begin
            len_we   = 1'b1;
            count_in = count_ff + 5'd1;
            pend_in  = '{KIND_VERDICT, dropped_ff ? VERD_DROPPED : VERD_STORED,
                         8'd0, 1'b0, 1'b1};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load     = 1'b1;
               rsp_in   = pend_ff;
               state_in = S_IDLE;
            end
         end
         S_TK_RD: state_in = S_TK_OUT;
         S_TK_OUT: begin
            if (out_free) begin
               load   = 1'b1;
               rsp_in = '{KIND_CHAR, VERD_STORED, id_rd_ff, 1'b0,
                          (k_ff + 6'd1 == len_ff)};
               if (k_ff + 6'd1 == len_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 6'd1;
                  state_in = S_TK_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load)            rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_len_ff  <= '0;
         overflow_ff  <= 1'b0;
         max_ff       <= 5'd1;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_len_ff  <= line_len_in;
         overflow_ff  <= overflow_in;
         max_ff       <= max_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      match_s_ff <= match_s_in;
      match_n_ff <= match_n_in;
      hex_dig_ff <= hex_dig_in;
      hex_ok_ff  <= hex_ok_in;
      is_s_ff    <= is_s_in;
      len_ff     <= len_in;
      k_ff       <= k_in;
      mism_ff    <= mism_in;
      dropped_ff <= dropped_in;
      slot_ff    <= slot_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_len_ff[LineAw-1:0]] <= req_data.rx_byte;
      line_rd_ff <= line_mem[line_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (id_we) id_mem[id_addr] <= cand_char;
      id_rd_ff <= id_mem[id_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) id_len_ff[slot_ff] <= len_ff;
   end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for fdxb_tag_line_parser_fifo_core: drives lines and takes,
// predicts verdicts and taken ID characters, and checks every rsp beat in order.
// Depends on fdxb_pkg and the core RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fdxb_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int Settle     = 150;
   localparam int WantDepth  = 1024;

   class tag_scoreboard;
      logic [7:0] line_buf[32];
      int         line_len;
      bit         line_ovf;
      logic [7:0] ids[16][32];
      int         id_len[16];
      int         head;
      int         count;
      int         max_ent;
      rsp_type    want[WantDepth];
      int         want_wr;
      int         want_rd;
      int         errors;
      int         seen;

      function new();
         line_len = 0;
         line_ovf = 0;
         head     = 0;
         count    = 0;
         max_ent  = 1;
         want_wr  = 0;
         want_rd  = 0;
         errors   = 0;
         seen     = 0;
      endfunction

      function int pending();
         return want_wr - want_rd;
      endfunction

      function void set_limit(logic [4:0] v);
         if (v != 0) max_ent = v;
      endfunction

      function void add(logic [1:0] k, logic [1:0] v, logic [7:0] c, logic e, logic l);
         rsp_type r;
         r.kind = k;
         r.verdict = v;
         r.id_char = c;
         r.id_empty = e;
         r.last = l;
         want[want_wr % WantDepth] = r;
         want_wr++;
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function bit parse_line(output logic [7:0] id[48], output int n);
         string      hs;
         string      hn;
         int         pos[8];
         bit         match;
         logic [63:0] val;
         int         nd;
         int         d;
         logic [7:0] dig[10];
         hs = ":FDXB(S)=";
         hn = ":FDXB=";
         pos = '{6, 7, 4, 5, 2, 3, 0, 1};
         n = 0;
         if (line_ovf) return 0;
         match = (line_len >= 9);
         for (int i = 0; i < 9 && match; i++) if (line_buf[i] != hs[i]) match = 0;
         if (match) begin
            n = line_len - 9;
            for (int i = 0; i < n; i++) id[i] = line_buf[9 + i];
            return 1;
         end
         match = (line_len >= 6);
         for (int i = 0; i < 6 && match; i++) if (line_buf[i] != hn[i]) match = 0;
         if (!match || line_len - 6 < 8) return 0;
         val = 0;
         nd = 0;
         for (int i = 0; i < 8; i++) begin
            d = hex_digit(line_buf[6 + pos[i]]);
            if (d < 0) break;
            val = val * 16 + d;
            nd++;
         end
         if (nd == 0) return 0;
         if (val > 64'd2147483647) val = 64'd2147483647;
         nd = 0;
         do begin
            dig[nd] = 8'h30 + 8'(val % 10);
            nd++;
            val = val / 10;
         end while (val != 0 && nd < 10);
         for (int i = 0; i < 6; i++) id[i] = (i < 3) ? "9" : "0";
         n = 6;
         for (int i = nd; i < 9; i++) begin
            id[n] = "0";
            n++;
         end
         while (nd > 0) begin
            nd--;
            id[n] = dig[nd];
            n++;
         end
         return 1;
      endfunction

      function logic [1:0] close_line();
         logic [7:0] id[48];
         int         n;
         int         nw;
         int         lim;
         int         slot;
         bit         ok;
         bit         same;
         bit         dropped;
         ok = parse_line(id, n);
         line_len = 0;
         line_ovf = 0;
         dropped = 0;
         if (!ok || n > 32) return VERD_REJECT;
         if (count > 0) begin
            nw = (head + count - 1) % 16;
            same = (id_len[nw] == n);
            for (int i = 0; i < n && same; i++) if (ids[nw][i] != id[i]) same = 0;
            if (same) return VERD_DUP;
         end
         lim = (max_ent > 16) ? 16 : max_ent;
         while (count >= lim) begin
            head = (head + 1) % 16;
            count--;
            dropped = 1;
         end
         slot = (head + count) % 16;
         for (int i = 0; i < n; i++) ids[slot][i] = id[i];
         id_len[slot] = n;
         count++;
         return dropped ? VERD_DROPPED : VERD_STORED;
      endfunction

      function void note_req(req_type r);
         int slot;
         if (r.operation == OP_BYTE) begin
            if (r.rx_byte == CHAR_CR) add(KIND_VERDICT, close_line(), 8'h00, 1'b0, 1'b1);
            else if (line_len < 32) begin
               line_buf[line_len] = r.rx_byte;
               line_len++;
            end else line_ovf = 1;
         end else if (count == 0) begin
            add(KIND_EMPTY, VERD_STORED, 8'h00, 1'b0, 1'b1);
         end else begin
            slot = head;
            head = (head + 1) % 16;
            count--;
            if (id_len[slot] == 0) add(KIND_CHAR, VERD_STORED, 8'h00, 1'b1, 1'b1);
            for (int i = 0; i < id_len[slot]; i++)
               add(KIND_CHAR, VERD_STORED, ids[slot][i], 1'b0, i + 1 == id_len[slot]);
         end
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type exp_rsp;
         seen++;
         if (pending() == 0) begin
            errors++;
            $display("%0t: unexpected rsp beat %p", $time, got);
            return;
         end
         exp_rsp = want[want_rd % WantDepth];
         want_rd++;
         if (got.kind != exp_rsp.kind)
            $display("%0t: kind exp %0d got %0d", $time, exp_rsp.kind, got.kind);
         if (got.verdict != exp_rsp.verdict)
            $display("%0t: verdict exp %0d got %0d", $time, exp_rsp.verdict, got.verdict);
         if (got.id_char != exp_rsp.id_char)
            $display("%0t: id_char exp %h got %h", $time, exp_rsp.id_char, got.id_char);
         if (got.id_empty != exp_rsp.id_empty)
            $display("%0t: id_empty exp %b got %b", $time, exp_rsp.id_empty, got.id_empty);
         if (got.last != exp_rsp.last)
            $display("%0t: last exp %b got %b", $time, exp_rsp.last, got.last);
         if (got !== exp_rsp) errors++;
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [4:0] csr_wdata;

   tag_scoreboard sb;
   int          cycles;
   int          items_sent;
   int          lines_sent;
   int          hold_asks;
   int          holds_served;
   bit          quiet;
   logic [7:0]  prev_buf[64];
   int          prev_n;

   fdxb_tag_line_parser_fifo_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_rsp(rsp_data);
   end

   // receiver: random stall, or a long hold when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_asks) begin
            holds_served = holds_served + 1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 26);
         end
      end
   end

   task automatic push(logic op, logic [7:0] b);
      req_type r;
      r.operation = op;
      r.rx_byte = b;
      if (!quiet && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_req(r);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) push(OP_BYTE, s[i]);
   endtask

   task automatic end_line();
      push(OP_BYTE, CHAR_CR);
      lines_sent++;
   endtask

   // hold the sender until every pending beat is back, then let the core settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_limit(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_limit(v);
   endtask

   function automatic logic [7:0] any_but_cr();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CHAR_CR);
      return b;
   endfunction

   function automatic logic [7:0] hex_char();
      string hx;
      hx = "0123456789abcdefABCDEF";
      return hx[$urandom_range(21)];
   endfunction

   task automatic random_line();
      logic [7:0] q[64];
      int         qn;
      string      hn;
      string      hs;
      int         pick;
      int         n;
      hn = ":FDXB=";
      hs = ":FDXB(S)=";
      qn = 0;
      pick = $urandom_range(99);
      if (pick < 83 && pick >= 75) begin
         push(OP_TAKE, 8'($urandom_range(255)));
         return;
      end
      if (pick < 35 || pick >= 83 && pick < 90) begin
         for (int i = 0; i < 6; i++) begin
            q[qn] = hn[i];
            qn++;
         end
         if (pick >= 83) q[$urandom_range(5)] = any_but_cr();
         n = ($urandom_range(9) == 0) ? $urandom_range(7) : 8 + $urandom_range(3);
         for (int i = 0; i < n; i++) begin
            q[qn] = ($urandom_range(99) < 88) ? hex_char() : any_but_cr();
            qn++;
         end
      end else if (pick < 65) begin
         for (int i = 0; i < 9; i++) begin
            q[qn] = hs[i];
            qn++;
         end
         n = $urandom_range(12);
         for (int i = 0; i < n; i++) begin
            q[qn] = any_but_cr();
            qn++;
         end
      end else if (pick < 75) begin
         for (int i = 0; i < prev_n; i++) q[i] = prev_buf[i];
         qn = prev_n;
      end else begin
         n = $urandom_range(12);
         for (int i = 0; i < n; i++) begin
            q[qn] = 8'($urandom_range(255));
            qn++;
         end
      end
      for (int i = 0; i < qn; i++) prev_buf[i] = q[i];
      prev_n = qn;
      for (int i = 0; i < qn; i++) push(OP_BYTE, q[i]);
      end_line();
      if ($urandom_range(99) < 35) push(OP_TAKE, 8'($urandom_range(255)));
   endtask

   initial begin
      sb = new();
      cycles = 0;
      items_sent = 0;
      lines_sent = 0;
      hold_asks = 0;
      holds_served = 0;
      quiet = 0;
      prev_n = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed at the reset limit of one: empty take, saturation, duplicate,
      // a line of exactly 32 bytes, drop of the oldest, empty S id and its
      // duplicate, overflow and a take on the emptied queue
      push(OP_TAKE, 8'h00);
      send_text(":FDXB=FFFFFFFF");
      end_line();
      send_text(":FDXB=FFFFFFFF");
      end_line();
      push(OP_TAKE, 8'hFF);
      quiet = 1;
      send_text(":FDXB(S)=abcdefghijklmnopqrstuvw");
      end_line();
      send_text(":FDXB(S)=");
      end_line();
      send_text(":FDXB(S)=");
      end_line();
      push(OP_TAKE, 8'h00);
      send_text(":FDXB(S)=abcdefghijklmnopqrstuvwx");
      push(OP_BYTE, 8'h00);
      end_line();
      push(OP_TAKE, 8'h00);
      quiet = 0;
      drain();

      // a random line under a limit of three
      write_limit(5'd3);
      random_line();
      push(OP_TAKE, 8'($urandom_range(255)));
      drain();

      // a zero write is ignored; then a limit above the depth, under a long hold
      write_limit(5'd0);
      write_limit(5'd31);
      hold_asks = hold_asks + 1;
      random_line();
      push(OP_TAKE, 8'($urandom_range(255)));
      random_line();
      drain();

      $display("tb: %0d items, %0d lines, %0d rsp beats checked", items_sent,
               lines_sent, sb.seen);
      $display("tb: edge lines at limit one, random lines at limits three and 31");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/fdxb_pkg.sv
rtl/core/fdxb_b2d.sv
rtl/core/fdxb_tag_line_parser_fifo_core.sv
tb/sv/tb.sv
